// ----- sv/polygon_orientation_degeneracy_check_assert.svh -----
// Assertion macros for the polygon orientation and degeneracy check.
// Used by the top level; relies on the clock and reset names of that module.
`ifndef POLYGON_ORIENTATION_DEGENERACY_CHECK_ASSERT_SVH
`define POLYGON_ORIENTATION_DEGENERACY_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PODC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("podc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PODC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("podc assertion failed");

`else

`define PODC_ASSERT_SAME(label, ante, cons)
`define PODC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- sv/podc_pkg.sv -----
// Package for the polygon orientation and degeneracy check.
// Holds field widths, register codes and the saturating area helper; no dependencies.
package podc_pkg;

   localparam int NODE_W           = 24;
   localparam int AREA_W           = 55;
   localparam int TOL_W            = 54;
   localparam int COORD_BITS_DFLT  = 24;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 64;
   localparam int CSR_IDX_LSB      = 3;

   localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
   localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

   typedef enum logic {
      CSR_AREA_TOLERANCE = 1'b0
   } csr_reg_type;

   // Clamps a sum that carries one guard bit back into the area range.
   function automatic logic signed [AREA_W-1:0] sat_area(input logic signed [AREA_W:0] s);
      logic signed [AREA_W-1:0] r;
      if (s[AREA_W] != s[AREA_W-1]) begin
         r = s[AREA_W] ? AREA_MIN : AREA_MAX;
      end else begin
         r = s[AREA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/polygon_orientation_degeneracy_check.sv -----
// Polygon orientation and degeneracy check: shoelace area with saturation, repeat and tolerance tests.
// Depends on podc_pkg and polygon_orientation_degeneracy_check_assert.svh.
//
//   channel  | direction | handshake          | beat contents
//   req_     | in        | req_valid/ready    | node_id, x_coord, y_coord, last_vertex
//   rsp_     | out       | rsp_valid/ready    | doubled_area and four flags, closing beat only
//   csr_     | in/out    | APB, pready tied 1 | area_tolerance at byte address 0
//
// One vertex beat is taken every cycle unless a stall on rsp_ready backs up to stage one.
// The pipeline has five register stages; rsp_valid rises when the closing vertex enters the fifth.
// Stage three loops through the accumulator and stage one through its polygon state.
// Stalls on rsp_ready pass back combinationally through full stages; empty stages still fill.
// Reset is synchronous and clears the valid bits, polygon state, accumulator and tolerance.

`include "polygon_orientation_degeneracy_check_assert.svh"

module polygon_orientation_degeneracy_check
   import podc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [NODE_W-1:0]             req_node_id,
   input  logic signed [COORD_BITS-1:0]  req_x_coord,
   input  logic signed [COORD_BITS-1:0]  req_y_coord,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [AREA_W-1:0]      rsp_doubled_area,
   output logic                          rsp_is_clockwise,
   output logic                          rsp_has_repeat,
   output logic                          rsp_area_too_small,
   output logic                          rsp_delete_element,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int CW = COORD_BITS + 1;
   localparam int TW = 2 * COORD_BITS + 2;

   logic [TOL_W-1:0] tol_ff;
   csr_reg_type      csr_idx;

   logic                    in_poly_ff;
   logic [NODE_W-1:0]       first_node_ff, prev_node_ff;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                    v1_in, v2_in, v3_in, v4_in, v5_in;
   logic                    rdy1, rdy2, rdy3, rdy4, rdy5;
   logic                    req_fire;

   logic                    start_in, rep1_in;
   logic [NODE_W-1:0]       first_node_eff;
   logic signed [COORD_BITS-1:0] first_x_eff, first_y_eff;
   logic signed [CW-1:0]    sa_in, da_in, sb_in, db_in;
   logic signed [CW-1:0]    sa1_ff, da1_ff, sb1_ff, db1_ff;
   logic                    start1_ff, last1_ff, rep1_ff;

   logic signed [TW-1:0]    sa_x, da_x, sb_x, db_x, ta_in, tb_in;
   logic signed [TW-1:0]    ta2_ff, tb2_ff;
   logic                    start2_ff, last2_ff, rep2_ff;

   logic signed [AREA_W-1:0] acc_ff, acc_in, s1;
   logic                     rep_acc_ff, rep_acc_in, rep_total;
   logic signed [AREA_W-1:0] s3_ff;
   logic signed [TW-1:0]     tb3_ff;
   logic                     rep3_ff;

   logic signed [AREA_W-1:0] sum4_in, sum4_ff;
   logic                     rep4_ff;

   logic [AREA_W-1:0]        mag;
   logic                     small_in;
   logic signed [AREA_W-1:0] area5_ff;
   logic                     cw5_ff, rep5_ff, small5_ff;

   // Configuration port.
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_IDX_LSB]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         CSR_AREA_TOLERANCE: csr_prdata = {{(CSR_DATA_W-TOL_W){1'b0}}, tol_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_idx == CSR_AREA_TOLERANCE) begin
         tol_ff <= csr_pwdata[TOL_W-1:0];
      end
   end

   // Stage ready chain.
   assign rdy5      = !v5_ff || rsp_ready;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign req_fire  = req_valid && req_ready;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? (v2_ff && last2_ff) : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Stage one: polygon bookkeeping and the edge sums and differences.
   assign start_in       = !in_poly_ff;
   assign first_node_eff = start_in ? req_node_id : first_node_ff;
   assign first_x_eff    = start_in ? req_x_coord : first_x_ff;
   assign first_y_eff    = start_in ? req_y_coord : first_y_ff;
   assign rep1_in        = (!start_in && req_node_id == prev_node_ff) ||
                           (req_last_vertex && req_node_id == first_node_eff);
   assign sa_in = CW'(prev_x_ff) + CW'(req_x_coord);
   assign da_in = CW'(req_y_coord) - CW'(prev_y_ff);
   assign sb_in = CW'(req_x_coord) + CW'(first_x_eff);
   assign db_in = CW'(first_y_eff) - CW'(req_y_coord);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_poly_ff    <= 1'b0;
         first_node_ff <= '0;
         prev_node_ff  <= '0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else if (req_fire) begin
         in_poly_ff    <= !req_last_vertex;
         first_node_ff <= first_node_eff;
         first_x_ff    <= first_x_eff;
         first_y_ff    <= first_y_eff;
         prev_node_ff  <= req_node_id;
         prev_x_ff     <= req_x_coord;
         prev_y_ff     <= req_y_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sa1_ff    <= sa_in;
         da1_ff    <= da_in;
         sb1_ff    <= sb_in;
         db1_ff    <= db_in;
         start1_ff <= start_in;
         last1_ff  <= req_last_vertex;
         rep1_ff   <= rep1_in;
      end
   end

   // Stage two: the edge products ta and tb.
   assign sa_x  = TW'(sa1_ff);
   assign da_x  = TW'(da1_ff);
   assign sb_x  = TW'(sb1_ff);
   assign db_x  = TW'(db1_ff);
   assign ta_in = start1_ff ? '0 : sa_x * da_x;
   assign tb_in = sb_x * db_x;

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         ta2_ff    <= ta_in;
         tb2_ff    <= tb_in;
         start2_ff <= start1_ff;
         last2_ff  <= last1_ff;
         rep2_ff   <= rep1_ff;
      end
   end

   // Stage three: running sum, cleared when a polygon closes.
   assign s1        = sat_area((AREA_W+1)'(acc_ff) + (AREA_W+1)'(ta2_ff));
   assign rep_total = rep_acc_ff || rep2_ff;

   always_comb begin
      acc_in     = acc_ff;
      rep_acc_in = rep_acc_ff;
      if (v2_ff && rdy3) begin
         acc_in     = last2_ff ? '0 : s1;
         rep_acc_in = last2_ff ? 1'b0 : rep_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         rep_acc_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         rep_acc_ff <= rep_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3 && last2_ff) begin
         s3_ff   <= s1;
         tb3_ff  <= tb2_ff;
         rep3_ff <= rep_total;
      end
   end

   // Stage four: closing edge term.
   assign sum4_in = sat_area((AREA_W+1)'(s3_ff) + (AREA_W+1)'(tb3_ff));

   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         sum4_ff <= sum4_in;
         rep4_ff <= rep3_ff;
      end
   end

   // Stage five: orientation and tolerance test into the result register.
   assign mag      = sum4_ff[AREA_W-1] ? AREA_W'(-sum4_ff) : AREA_W'(sum4_ff);
   assign small_in = !rep4_ff && (mag <= {1'b0, tol_ff});

   always_ff @(posedge clock) begin
      if (v4_ff && rdy5) begin
         area5_ff  <= sum4_ff;
         cw5_ff    <= sum4_ff[AREA_W-1];
         rep5_ff   <= rep4_ff;
         small5_ff <= small_in;
      end
   end

   assign rsp_valid          = v5_ff;
   assign rsp_doubled_area   = area5_ff;
   assign rsp_is_clockwise   = cw5_ff;
   assign rsp_has_repeat     = rep5_ff;
   assign rsp_area_too_small = small5_ff;
   assign rsp_delete_element = rep5_ff || small5_ff;

   `PODC_ASSERT_SAME(a_new_poly_clean, v2_ff && start2_ff, acc_ff == '0 && !rep_acc_ff)
   `PODC_ASSERT_NEXT(a_close_ends_poly, req_fire && req_last_vertex, !in_poly_ff)
   `PODC_ASSERT_SAME(a_repeat_not_small, rsp_valid && rsp_has_repeat, !rsp_area_too_small)

endmodule

// ----- test/tb_polygon_orientation_degeneracy_check.sv -----
// Self-checking bench for polygon_orientation_degeneracy_check: drives vertex beats and
// APB tolerance writes, predicts each element verdict and checks every result beat.
// Depends on podc_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 100ps

module tb_polygon_orientation_degeneracy_check;
   import podc_pkg::*;

   localparam int COORD_W = COORD_BITS_DFLT;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam longint SUM_HI = (longint'(1) <<< (AREA_W-1)) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< (AREA_W-1));
   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR =
      CSR_ADDR_W'(CSR_AREA_TOLERANCE) << CSR_IDX_LSB;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = TOL_ADDR + CSR_ADDR_W'(1 << CSR_IDX_LSB);

   typedef enum {SPREAD_FULL, SPREAD_NEAR, SPREAD_LINE, SPREAD_EDGE} spread_type;

   typedef struct {
      logic [NODE_W-1:0]         node;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      bit                        closing;
   } vertex_beat_type;

   typedef struct {
      logic signed [AREA_W-1:0] area;
      bit                       clockwise;
      bit                       repeated;
      bit                       undersized;
      bit                       doomed;
   } verdict_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [NODE_W-1:0]            req_node_id = '0;
   logic signed [COORD_W-1:0]    req_x_coord = '0;
   logic signed [COORD_W-1:0]    req_y_coord = '0;
   logic                         req_last_vertex = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [AREA_W-1:0]     rsp_doubled_area;
   logic                         rsp_is_clockwise;
   logic                         rsp_has_repeat;
   logic                         rsp_area_too_small;
   logic                         rsp_delete_element;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_paddr = '0;
   logic [CSR_DATA_W-1:0]        csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   polygon_orientation_degeneracy_check #(.COORD_BITS(COORD_W)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_node_id        (req_node_id),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_doubled_area   (rsp_doubled_area),
      .rsp_is_clockwise   (rsp_is_clockwise),
      .rsp_has_repeat     (rsp_has_repeat),
      .rsp_area_too_small (rsp_area_too_small),
      .rsp_delete_element (rsp_delete_element),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #5 clock = ~clock;

   logic signed [COORD_W-1:0] open_x = '0, open_y = '0, prior_x = '0, prior_y = '0;
   logic [NODE_W-1:0]         open_node = '0, prior_node = '0;
   longint                    shoelace = 0;
   bit                        repeat_hit = 1'b0, mid_polygon = 1'b0;
   logic [TOL_W-1:0]          tolerance_now = '0;

   vertex_beat_type pending_vertices[$];
   verdict_type     verdicts_due[$];
   vertex_beat_type beat_on_bus;
   int              queued_count = 0, accepted_count = 0;
   int              send_gap = 0, stall_left = 0, mismatches = 0;
   bit              req_idle_on = 1'b0, rsp_idle_on = 1'b0;

   function automatic longint clamp_sum(input longint s);
      if (s > SUM_HI) return SUM_HI;
      if (s < SUM_LO) return SUM_LO;
      return s;
   endfunction

   function automatic longint edge_product(input logic signed [COORD_W-1:0] xa, ya, xb, yb);
      return (longint'(xa) + longint'(xb)) * (longint'(yb) - longint'(ya));
   endfunction

   // Folds one accepted vertex into the polygon and queues the verdict on the closing one.
   task automatic accumulate_vertex(input vertex_beat_type v);
      verdict_type due;
      longint      mag;
      if (!mid_polygon) begin
         open_x = v.x;
         open_y = v.y;
         open_node = v.node;
         shoelace = 0;
         repeat_hit = 1'b0;
         mid_polygon = 1'b1;
      end else begin
         shoelace = clamp_sum(shoelace + edge_product(prior_x, prior_y, v.x, v.y));
         if (v.node == prior_node) repeat_hit = 1'b1;
      end
      prior_x = v.x;
      prior_y = v.y;
      prior_node = v.node;
      if (v.closing) begin
         shoelace = clamp_sum(shoelace + edge_product(v.x, v.y, open_x, open_y));
         if (v.node == open_node) repeat_hit = 1'b1;
         mag = (shoelace < 0) ? -shoelace : shoelace;
         due.area = shoelace[AREA_W-1:0];
         due.clockwise = shoelace < 0;
         due.repeated = repeat_hit;
         due.undersized = !repeat_hit && (mag <= longint'({1'b0, tolerance_now}));
         due.doomed = due.repeated || due.undersized;
         verdicts_due.push_back(due);
         mid_polygon = 1'b0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord(input spread_type spread);
      case (spread)
         SPREAD_NEAR: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
         SPREAD_EDGE: begin
            case ($urandom_range(0, 3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic push_vertex(input int node, x, y, closing);
      vertex_beat_type v;
      v.node = NODE_W'(node);
      v.x = COORD_W'(x);
      v.y = COORD_W'(y);
      v.closing = (closing != 0);
      pending_vertices.push_back(v);
      queued_count++;
   endtask

   task automatic add_random_polygon();
      int                        len, r, bx, by, dx, dy, step;
      spread_type                spread;
      logic [NODE_W-1:0]         node, first, prev;
      logic signed [COORD_W-1:0] x, y;
      r = $urandom_range(0, 99);
      len = (r < 5) ? 1 : (r < 10) ? 2 : (r < 85) ? $urandom_range(3, 8)
                                                  : $urandom_range(9, 20);
      spread = spread_type'($urandom_range(0, 3));
      bx = int'($urandom_range(0, 65535)) - 32768;
      by = int'($urandom_range(0, 65535)) - 32768;
      dx = int'($urandom_range(0, 128)) - 64;
      dy = int'($urandom_range(0, 128)) - 64;
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (k > 0 && r < 8) begin
            node = prev;
         end else if (k > 0 && k == len - 1 && r < 16) begin
            node = first;
         end else begin
            node = NODE_W'($urandom);
         end
         if (k == 0) first = node;
         prev = node;
         if (spread == SPREAD_LINE) begin
            step = $urandom_range(0, 20);
            x = COORD_W'(bx + step * dx);
            y = COORD_W'(by + step * dy);
         end else begin
            x = pick_coord(spread);
            y = pick_coord(spread);
         end
         push_vertex(node, x, y, k == len - 1);
      end
   endtask

   // Walks the full-range rectangle many times so the running sum hits its clamp.
   task automatic add_winding(input int turns, input bit clockwise);
      logic signed [COORD_W-1:0] cx[4], cy[4];
      int                        c;
      cx = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
      cy = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX};
      for (int k = 0; k < 4 * turns; k++) begin
         c = clockwise ? 3 - (k % 4) : k % 4;
         push_vertex(NODE_W'(100 + c), cx[c], cy[c], k == 4 * turns - 1);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if ((addr >> CSR_IDX_LSB) == CSR_AREA_TOLERANCE) tolerance_now = data[TOL_W-1:0];
   endtask

   task automatic drain();
      while (accepted_count != queued_count || verdicts_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_vertex(beat_on_bus);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_vertices.size() != 0) begin
               beat_on_bus = pending_vertices.pop_front();
               req_node_id <= beat_on_bus.node;
               req_x_coord <= beat_on_bus.x;
               req_y_coord <= beat_on_bus.y;
               req_last_vertex <= beat_on_bus.closing;
               req_valid <= 1'b1;
               send_gap = req_idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result beat with none expected, area %0d", $time,
                           rsp_doubled_area);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_doubled_area !== want.area || rsp_is_clockwise !== want.clockwise ||
                   rsp_has_repeat !== want.repeated ||
                   rsp_area_too_small !== want.undersized ||
                   rsp_delete_element !== want.doomed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected area %0d cw %b rep %b small %b del %b,",
                              $time, want.area, want.clockwise, want.repeated,
                              want.undersized, want.doomed,
                              " got %0d %b %b %b %b", rsp_doubled_area,
                              rsp_is_clockwise, rsp_has_repeat, rsp_area_too_small,
                              rsp_delete_element);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Tolerance is still at its reset value of zero here.
      push_vertex(1, 0, 0, 0);
      push_vertex(2, 256, 0, 0);
      push_vertex(3, 0, 256, 1);
      push_vertex(4, 0, 0, 0);
      push_vertex(5, 0, 256, 0);
      push_vertex(6, 256, 0, 1);
      push_vertex(7, COORD_MAX, COORD_MIN, 1);
      push_vertex(8, COORD_MIN, COORD_MIN, 0);
      push_vertex(9, COORD_MAX, COORD_MAX, 1);
      push_vertex(10, 512, -512, 0);
      push_vertex(10, 1024, 768, 0);
      push_vertex(11, -300, 40, 1);
      push_vertex(12, 5, 5, 0);
      push_vertex(13, 900, 5, 0);
      push_vertex(12, 5, 900, 1);
      push_vertex('0, COORD_MIN, COORD_MIN, 0);
      push_vertex('1, COORD_MAX, COORD_MIN, 0);
      push_vertex(14, COORD_MAX, COORD_MAX, 0);
      push_vertex(15, COORD_MIN, COORD_MAX, 1);
      push_vertex(16, COORD_MIN, COORD_MAX, 0);
      push_vertex(17, COORD_MAX, COORD_MAX, 0);
      push_vertex(18, COORD_MAX, COORD_MIN, 0);
      push_vertex(19, COORD_MIN, COORD_MIN, 1);
      push_vertex(20, -100, -100, 0);
      push_vertex(21, 0, 0, 0);
      push_vertex(22, 100, 100, 1);
      drain();

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      csr_write(TOL_ADDR, '1);
      repeat (12) add_random_polygon();
      add_winding(34, 1'b0);
      add_winding(34, 1'b1);
      drain();

      rsp_idle_on = 1'b0;
      csr_write(TOL_ADDR, CSR_DATA_W'(1) << 26);
      repeat (12) add_random_polygon();
      drain();

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      csr_write(SPARE_ADDR, '0);
      repeat (10) add_random_polygon();
      drain();

      req_idle_on = 1'b1;
      csr_write(TOL_ADDR, {$urandom, $urandom} >> 30);
      repeat (12) add_random_polygon();
      drain();

      csr_write(TOL_ADDR, '0);
      repeat (9) add_random_polygon();
      drain();

      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("polygon_orientation_degeneracy_check regression: pass");
      end else begin
         $display("polygon_orientation_degeneracy_check regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("polygon_orientation_degeneracy_check regression: fail");
      $finish;
   end

endmodule
